/* hdl/sine_tone_generator_unit_defines.svh */
// Assertion macros used by the checker file of the tone generator.
`ifndef SINE_TONE_GENERATOR_UNIT_DEFINES_SVH
`define SINE_TONE_GENERATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tone generator check failed");

// The consequent must hold in the cycle after the antecedent.
`define STG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tone generator check failed");

`endif

/* hdl/stg_pkg.sv */
package stg_pkg;

    localparam int DATA_W     = 16;
    localparam int PHASE_BITS = 12;
    localparam int QTR_BITS   = PHASE_BITS - 2;
    localparam int QTR_SIZE   = 1 << QTR_BITS;
    localparam int ADDR_W     = QTR_BITS + 1;
    localparam int MAG_W      = 15;
    localparam int CNT_W      = $clog2(DATA_W);
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_TONE_FREQ = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_HZ   = 1'b1;

    localparam logic [DATA_W-1:0] RATE_HZ_RESET = 16'd48000;

    // pi/2 in unsigned Q60.
    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

    typedef logic [MAG_W-1:0] qtr_rom_t [QTR_SIZE+1];

    typedef struct packed {
        logic start;
        logic step_mod;
        logic load_idx;
        logic step_idx;
        logic rom_rd;
        logic out_load;
    } stg_cmd_t;

    // Product of two Q60 values below 2^61, returned in Q60.
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[123:60];
    endfunction

    // Unsigned long division by shift and subtract, used while building the table.
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] part;
        logic [63:0] quo;
        part = '0;
        quo  = '0;
        for (int i = 63; i >= 0; i--) begin
            part = {part[63:0], num[i]};
            if (part >= {1'b0, den}) begin
                part   = part - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave table: floor(16384*sin(pi/2*q/QTR_SIZE)) from a Taylor series.
    // Evaluated once at elaboration.
    function automatic qtr_rom_t build_qtr_rom();
        qtr_rom_t    rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] den;
        logic        add;
        for (int q = 0; q <= QTR_SIZE; q++) begin
            if (q == 0) begin
                rom[q] = '0;
            end
            else if (q == QTR_SIZE) begin
                rom[q] = MAG_W'(16384);
            end
            else begin
                x    = mul_q60(HALF_PI_Q60, 64'(q) << (62 - PHASE_BITS));
                x2   = mul_q60(x, x);
                term = x;
                sum  = x;
                add  = 1'b0;
                for (int k = 1; k < 40; k++) begin
                    if (term != 64'd0) begin
                        den  = 64'((2 * k) * (2 * k + 1));
                        term = div_u64(mul_q60(term, x2), den);
                        if (add) begin
                            sum = sum + term;
                        end
                        else begin
                            sum = sum - term;
                        end
                        add = !add;
                    end
                end
                rom[q] = sum[46+MAG_W-1:46];
            end
        end
        return rom;
    endfunction

endpackage

/* hdl/stg_div.sv */
module stg_div (
    input  logic                        clk,
    input  logic                        load,
    input  logic                        step,
    input  logic [stg_pkg::DATA_W-1:0]  acc_init,
    input  logic [stg_pkg::DATA_W-1:0]  dvd_init,
    input  logic [stg_pkg::DATA_W-1:0]  divisor,
    output logic [stg_pkg::DATA_W-1:0]  rem,
    output logic [stg_pkg::DATA_W-1:0]  quo
);
    import stg_pkg::*;

    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] dvd_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              fits;

    // One restoring shift-subtract step; the partial remainder stays below the divisor.
    assign trial = {acc_reg, dvd_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_ff @(posedge clk) begin
        if (load) begin
            acc_reg <= acc_init;
            dvd_reg <= dvd_init;
            quo_reg <= '0;
        end
        else if (step) begin
            acc_reg <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            dvd_reg <= {dvd_reg[DATA_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
        end
    end

    assign rem = acc_reg;
    assign quo = quo_reg;

endmodule

/* hdl/stg_datapath.sv */
module stg_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  stg_pkg::stg_cmd_t              cmd,
    input  logic                           restart,
    input  logic                           cfg_we,
    input  logic [stg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stg_pkg::DATA_W-1:0]     cfg_data,
    output logic signed [stg_pkg::DATA_W-1:0] sample_left,
    output logic signed [stg_pkg::DATA_W-1:0] sample_right
);
    import stg_pkg::*;

    localparam qtr_rom_t QTR_ROM = build_qtr_rom();

    logic [DATA_W-1:0]     tone_freq_reg;
    logic [DATA_W-1:0]     rate_hz_reg;
    logic [DATA_W-1:0]     phase_rem_reg;
    logic [DATA_W-1:0]     phase_rem_next;
    logic [DATA_W-1:0]     rem_reg;
    logic [MAG_W-1:0]      mag_reg;
    logic                  neg_reg;
    logic [DATA_W-1:0]     sample_reg;
    logic [DATA_W-1:0]     fs;
    logic [DATA_W-1:0]     freq_mod;
    logic [DATA_W-1:0]     freq_quo;
    logic [DATA_W-1:0]     rem_b;
    logic [DATA_W-1:0]     quo_b;
    logic [DATA_W-1:0]     b_acc_init;
    logic [DATA_W-1:0]     b_dvd_init;
    logic [PHASE_BITS-1:0] idx;
    logic [1:0]            quad;
    logic [QTR_BITS-1:0]   qpos;
    logic [ADDR_W-1:0]     rom_addr;
    logic [DATA_W:0]       adv_sum;
    logic [DATA_W-1:0]     mag_w;
    logic [DATA_W-1:0]     word;

    // A sample rate of zero behaves as one.
    assign fs = (rate_hz_reg == '0) ? DATA_W'(1) : rate_hz_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tone_freq_reg <= '0;
            rate_hz_reg   <= RATE_HZ_RESET;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                REG_TONE_FREQ: tone_freq_reg <= cfg_data;
                REG_RATE_HZ:   rate_hz_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Divider A reduces the tone frequency; divider B reduces the remainder and
    // then forms the phase index.
    stg_div u_div_freq (
        .clk      (clk),
        .load     (cmd.start),
        .step     (cmd.step_mod),
        .acc_init ('0),
        .dvd_init (tone_freq_reg),
        .divisor  (fs),
        .rem      (freq_mod),
        .quo      (freq_quo)
    );

    assign b_acc_init = cmd.load_idx ? rem_b : '0;
    assign b_dvd_init = (cmd.load_idx || restart) ? '0 : phase_rem_reg;

    stg_div u_div_phase (
        .clk      (clk),
        .load     (cmd.start || cmd.load_idx),
        .step     (cmd.step_mod || cmd.step_idx),
        .acc_init (b_acc_init),
        .dvd_init (b_dvd_init),
        .divisor  (fs),
        .rem      (rem_b),
        .quo      (quo_b)
    );

    assign idx      = quo_b[PHASE_BITS-1:0];
    assign quad     = idx[PHASE_BITS-1 -: 2];
    assign qpos     = idx[QTR_BITS-1:0];
    // Odd quadrants run the quarter wave backward.
    assign rom_addr = quad[0] ? (ADDR_W'(QTR_SIZE) - {1'b0, qpos}) : {1'b0, qpos};

    assign adv_sum        = {1'b0, rem_reg} + {1'b0, freq_mod};
    assign phase_rem_next = (adv_sum >= {1'b0, fs}) ? DATA_W'(adv_sum - {1'b0, fs})
                                                    : adv_sum[DATA_W-1:0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_rem_reg <= '0;
        end
        else if (cmd.rom_rd) begin
            phase_rem_reg <= phase_rem_next;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load_idx) begin
            rem_reg <= rem_b;
        end
        if (cmd.rom_rd) begin
            mag_reg <= QTR_ROM[rom_addr];
            neg_reg <= quad[1];
        end
        if (cmd.out_load) begin
            sample_reg <= word;
        end
    end

    assign mag_w = DATA_W'(mag_reg);
    assign word  = neg_reg ? (DATA_W'(0) - mag_w) : mag_w;

    assign sample_left  = signed'(sample_reg);
    assign sample_right = signed'(sample_reg);

endmodule

/* hdl/stg_ctrl.sv */
module stg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output stg_pkg::stg_cmd_t cmd
);
    import stg_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MOD  = 3'd1;
    localparam logic [2:0] ST_IDXL = 3'd2;
    localparam logic [2:0] ST_IDX  = 3'd3;
    localparam logic [2:0] ST_ROM  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign in_stall = (state_reg != ST_IDLE);
    // The output register can take a new item when empty or being drained now.
    assign out_free = !out_valid_reg || !out_stall;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.start  = 1'b1;
                    cnt_next   = CNT_W'(DATA_W - 1);
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                cmd.step_mod = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_IDXL;
                end
            end
            ST_IDXL: begin
                cmd.load_idx = 1'b1;
                cnt_next     = CNT_W'(PHASE_BITS - 1);
                state_next   = ST_IDX;
            end
            ST_IDX: begin
                cmd.step_idx = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_ROM;
                end
            end
            ST_ROM: begin
                cmd.rom_rd = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* hdl/sine_tone_generator_unit.sv */
// Sine tone generator: each input item yields one stereo Q14 sample of a tone at
// the tone frequency register (index 0) for the sampling rate register (index 1),
// both in hertz; restart=1 starts the tone at phase zero. A new item is not
// accepted until the result of the previous one has been loaded into the
// output register. The work is done by two shift-subtract dividers: a
// 16-step pass that reduces frequency and phase remainder modulo the rate, a
// load of the second pass, a PHASE_BITS-step pass for the phase index, then a
// read of the quarter-wave table and a load into the output register. A
// finished sample waits in the output register while the next item is
// accepted. The user must write registers only while the block is idle; the
// block itself does not enforce this. cfg_ready is always high.
module sine_tone_generator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              restart,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [stg_pkg::DATA_W-1:0] sample_left,
    output logic signed [stg_pkg::DATA_W-1:0] sample_right,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [stg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stg_pkg::DATA_W-1:0]        cfg_data
);
    import stg_pkg::*;

    stg_cmd_t cmd;

    assign cfg_ready = 1'b1;

    stg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    stg_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .restart      (restart),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_left  (sample_left),
        .sample_right (sample_right)
    );

endmodule

/* hdl/stg_checker.sv */
`include "sine_tone_generator_unit_defines.svh"

module stg_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [stg_pkg::DATA_W-1:0] sample_left,
    input logic signed [stg_pkg::DATA_W-1:0] sample_right
);
    import stg_pkg::*;

    // Both channels carry the same sample.
    `STG_ASSERT_SAME(a_channels_match, clk, rst_n, out_valid, sample_left == sample_right)

    // A Q14 sine sample never leaves the unit circle.
    `STG_ASSERT_SAME(a_sample_range, clk, rst_n, out_valid,
        (sample_left >= -16'sd16384) && (sample_left <= 16'sd16384))

    // An accepted item keeps the block busy in the following cycle.
    `STG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // A result that was not taken stays offered and unchanged.
    `STG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(sample_left))

endmodule

bind sine_tone_generator_unit stg_checker u_stg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_left  (sample_left),
    .sample_right (sample_right)
);

/* verif/tb_sine_tone_generator_unit.sv */
module tb_sine_tone_generator_unit;
    import stg_pkg::*;

    typedef enum logic {ROW_ITEM, ROW_CFG} step_kind_t;

    typedef struct packed {
        step_kind_t               kind;
        logic [CFG_IDX_W-1:0]     index;
        logic [DATA_W-1:0]        data;
        logic                     rs;
        logic                     check;
        logic signed [DATA_W-1:0] want;
    } dir_step_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     restart = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] sample_left;
    logic signed [DATA_W-1:0] sample_right;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = REG_TONE_FREQ;
    logic [DATA_W-1:0]        cfg_data = '0;

    // Shadow copy of the block's registers and phase state.
    logic [DATA_W-1:0]        cfg_tone;
    logic [DATA_W-1:0]        cfg_rate;
    logic [DATA_W-1:0]        phase_rem;
    logic [MAG_W-1:0]         sine_qtr [0:QTR_SIZE];

    logic signed [DATA_W-1:0] samples_due [$];
    int                       errors = 0;
    int                       samples_seen = 0;
    int                       burst_left = 0;

    // Expected values are typed in where the phase lands on a quarter point.
    dir_step_t tone_script [36] = '{
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b1, 1'b1, 16'sd0},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b0, 1'b1, 16'sd0},
        '{ROW_CFG,  REG_RATE_HZ,   16'd4,     1'b0, 1'b0, 16'sd0},
        '{ROW_CFG,  REG_TONE_FREQ, 16'd1,     1'b0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b1, 1'b1, 16'sd0},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b0, 1'b1, 16'sd16384},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b0, 1'b1, 16'sd0},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b0, 1'b1, -16'sd16384},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b0, 1'b1, 16'sd0},
        '{ROW_CFG,  REG_TONE_FREQ, 16'd5,     1'b0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b1, 1'b1, 16'sd0},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b0, 1'b1, 16'sd16384},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b0, 1'b1, 16'sd0},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b0, 1'b1, -16'sd16384},
        '{ROW_CFG,  REG_TONE_FREQ, 16'd3,     1'b0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b1, 1'b1, 16'sd0},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b0, 1'b1, -16'sd16384},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b0, 1'b1, 16'sd0},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b0, 1'b1, 16'sd16384},
        '{ROW_CFG,  REG_RATE_HZ,   16'd8,     1'b0, 1'b0, 16'sd0},
        '{ROW_CFG,  REG_TONE_FREQ, 16'd7,     1'b0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b1, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b0, 1'b0, 16'sd0},
        '{ROW_CFG,  REG_RATE_HZ,   16'd3,     1'b0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b0, 1'b0, 16'sd0},
        '{ROW_CFG,  REG_RATE_HZ,   16'd0,     1'b0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b0, 1'b1, 16'sd0},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b1, 1'b1, 16'sd0},
        '{ROW_CFG,  REG_RATE_HZ,   16'hFFFF,  1'b0, 1'b0, 16'sd0},
        '{ROW_CFG,  REG_TONE_FREQ, 16'hFFFF,  1'b0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b1, 1'b1, 16'sd0},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b0, 1'b1, 16'sd0},
        '{ROW_CFG,  REG_TONE_FREQ, 16'hFFFE,  1'b0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_TONE_FREQ, 16'd0,     1'b0, 1'b0, 16'sd0}
    };

    sine_tone_generator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_left  (sample_left),
        .sample_right (sample_right),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("tb_sine_tone_generator_unit NOT OK");
        $finish;
    end

    // Fixed-point product of two Q60 operands, result in Q60.
    function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] wide;
        wide = {64'd0, a} * {64'd0, b};
        return wide[123:60];
    endfunction

    // Q14 magnitude of sin(pi/2 * q / QTR_SIZE), rounded down, by Taylor series.
    function automatic logic [MAG_W-1:0] quarter_sine(input int q);
        logic [63:0] x;
        logic [63:0] x_sq;
        logic [63:0] term;
        logic [63:0] acc;
        bit          plus;
        if (q == 0)
        begin
            return '0;
        end
        if (q >= QTR_SIZE)
        begin
            return MAG_W'(16384);
        end
        x    = q60_product(HALF_PI_Q60, 64'(q) << (62 - PHASE_BITS));
        x_sq = q60_product(x, x);
        term = x;
        acc  = x;
        plus = 1'b0;
        for (int k = 1; k < 40 && term != 64'd0; k++)
        begin
            term = q60_product(term, x_sq) / 64'((2 * k) * (2 * k + 1));
            acc  = plus ? acc + term : acc - term;
            plus = !plus;
        end
        return acc[46+MAG_W-1:46];
    endfunction

    // Sample for one item; advances the shadow phase remainder.
    function automatic logic signed [DATA_W-1:0] next_sine_sample(input logic rs);
        logic [16:0]       fs;
        logic [16:0]       f;
        logic [16:0]       r;
        logic [31:0]       idx;
        logic [1:0]        quad;
        int                q;
        logic [DATA_W-1:0] mag;
        fs = (cfg_rate == '0) ? 17'd1 : {1'b0, cfg_rate};
        f  = {1'b0, cfg_tone} % fs;
        if (rs)
        begin
            phase_rem = '0;
        end
        r    = {1'b0, phase_rem} % fs;
        idx  = ({15'd0, r} << PHASE_BITS) / {15'd0, fs};
        quad = idx[QTR_BITS+1:QTR_BITS];
        q    = int'(idx[QTR_BITS-1:0]);
        if (quad[0])
        begin
            q = QTR_SIZE - q;
        end
        mag = {1'b0, sine_qtr[q]};
        r   = r + f;
        if (r >= fs)
        begin
            r = r - fs;
        end
        phase_rem = r[DATA_W-1:0];
        return $signed(quad[1] ? DATA_W'(16'd0 - mag) : mag);
    endfunction

    task automatic send_item(input logic rs, input logic use_typed,
                             input logic signed [DATA_W-1:0] typed);
        int                       gap;
        logic signed [DATA_W-1:0] predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        restart  <= rs;
        do
            @(posedge clk);
        while (in_stall);
        predicted = next_sine_sample(rs);
        samples_due.push_back(use_typed ? typed : predicted);
        burst_left--;
    endtask

    // Stop offering items and wait for every expected sample to come out.
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (samples_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_TONE_FREQ)
        begin
            cfg_tone = value;
        end
        else
        begin
            cfg_rate = value;
        end
    endtask

    initial
    begin : stimulus
        logic [DATA_W-1:0] tone;
        logic [DATA_W-1:0] rate;
        for (int q = 0; q <= QTR_SIZE; q++)
        begin
            sine_qtr[q] = quarter_sine(q);
        end
        cfg_tone  = '0;
        cfg_rate  = RATE_HZ_RESET;
        phase_rem = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (tone_script[i])
        begin
            if (tone_script[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(tone_script[i].index, tone_script[i].data);
            end
            else
            begin
                send_item(tone_script[i].rs, tone_script[i].check, tone_script[i].want);
            end
        end

        for (int phase = 0; phase < 10; phase++)
        begin
            settle();
            tone = cfg_tone;
            case (phase)
                0:
                begin
                    tone = 16'd440;
                    rate = 16'd48000;
                end
                1:
                begin
                    tone = 16'hFFFF;
                    rate = 16'hFFFE;
                end
                2:
                begin
                    tone = 16'($urandom);
                    rate = 16'd1;
                end
                3:
                begin
                    tone = 16'($urandom);
                    rate = 16'd0;
                end
                4:
                begin
                    tone = 16'hFFFF;
                    rate = 16'($urandom_range(2, 300));
                end
                5:
                begin
                    tone = 16'd12345;
                    rate = 16'hFFFF;
                end
                6:
                begin
                    rate = 16'($urandom_range(1, 40));
                end
                7:
                begin
                    tone = 16'd3;
                    rate = 16'd7;
                end
                8:
                begin
                    tone = 16'($urandom);
                    rate = 16'($urandom_range(1, 65535));
                end
                default:
                begin
                    tone = 16'($urandom);
                    rate = 16'($urandom_range(1, 16));
                end
            endcase
            // Lowering only the rate leaves a remainder that may exceed it.
            if (phase != 6)
            begin
                write_reg(REG_TONE_FREQ, tone);
            end
            write_reg(REG_RATE_HZ, rate);
            repeat (200) send_item($urandom_range(0, 15) == 0, 1'b0, 16'sd0);
        end

        settle();
        repeat (40) @(posedge clk);
        if (errors == 0)
        begin
            $display("tb_sine_tone_generator_unit OK");
        end
        else
        begin
            $display("tb_sine_tone_generator_unit NOT OK");
        end
        $finish;
    end

    // Output side: stall patterns change after spans of random length, with one long
    // hold-off so that the block backs up into its input.
    initial
    begin : sink
        int mode;
        int span;
        bit long_hold_done;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 80);
            repeat (span)
            begin
                @(posedge clk);
                if (!long_hold_done && samples_seen >= 300)
                begin
                    long_hold_done = 1'b1;
                    out_stall <= 1'b1;
                    repeat (400) @(posedge clk);
                end
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= !out_stall;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : sample_check
        logic signed [DATA_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            samples_seen++;
            if (samples_due.size() == 0)
            begin
                errors++;
                $display("%0t: sample with nothing expected: expected none, actual %0d",
                         $time, sample_left);
            end
            else
            begin
                want = samples_due.pop_front();
                if (sample_left !== want)
                begin
                    errors++;
                    $display("%0t: sample_left expected %0d actual %0d",
                             $time, want, sample_left);
                end
                if (sample_right !== want)
                begin
                    errors++;
                    $display("%0t: sample_right expected %0d actual %0d",
                             $time, want, sample_right);
                end
            end
        end
    end

endmodule
